// ===== src/cbor_header_and_string_encoder_macros.svh =====
// Assertion macros shared by the CBOR encoder modules.
// No dependencies; included by the modules that carry checks.
`ifndef CBOR_HEADER_AND_STRING_ENCODER_MACROS_SVH
`define CBOR_HEADER_AND_STRING_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define CBE_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CBE_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg)
`define CBE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// ===== src/cbe_pkg.sv =====
// Shared types and constants for the CBOR header and string encoder.
// No dependencies.
package cbe_pkg;

  localparam int MESSAGE_CAPACITY = 4096;
  localparam int FILL_W = $clog2(MESSAGE_CAPACITY + 1);
  localparam int MAX_BEATS = 9;
  localparam int BEAT_W = $clog2(MAX_BEATS + 1);

  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_HEADER  = 2'd1;
  localparam logic [1:0] ACT_PAYLOAD = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ROOM      = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_UTF8      = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_BYTES = 2'd2;
  localparam logic [1:0] KIND_TEXT  = 2'd3;

  localparam logic [2:0] MT_BYTES = 3'd2;
  localparam logic [2:0] MT_TEXT  = 3'd3;

  localparam logic [4:0] MARK_1 = 5'd24;
  localparam logic [4:0] MARK_2 = 5'd25;
  localparam logic [4:0] MARK_4 = 5'd26;
  localparam logic [4:0] MARK_8 = 5'd27;

  // All beats caused by one input item; beat 0 is sent first.
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [BEAT_W-1:0]         count;
    logic                      has_byte;
    logic [1:0]                status;
  } result_t;

endpackage

// ===== src/cbe_encode_core.sv =====
// Message state and single-pass encoding of one item into up to nine bytes.
// Depends on cbe_pkg and the assertion macro header.
`include "cbor_header_and_string_encoder_macros.svh"

module cbe_encode_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [1:0]      action,
  input  logic [2:0]      major_type,
  input  logic [63:0]     argument,
  input  logic [7:0]      data_byte,
  output cbe_pkg::result_t result
);
  import cbe_pkg::*;

  localparam int NEED_W = FILL_W + 4;
  localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(MESSAGE_CAPACITY);
  localparam logic [NEED_W-1:0] CAP_NEED = NEED_W'(MESSAGE_CAPACITY);
  localparam logic [64:0]       CAP_WIDE = 65'(MESSAGE_CAPACITY);

  logic [FILL_W-1:0] fill_level, fill_level_next;
  logic [1:0]        error_status, error_status_next;
  logic [1:0]        string_kind, string_kind_next;
  logic [63:0]       payload_remaining, payload_remaining_next;
  logic [1:0]        continuation_pending, continuation_pending_next;
  logic              text_overflowed, text_overflowed_next;

  logic [3:0]        extra;
  logic [4:0]        marker;
  logic [63:0]       arg_left;
  logic [NEED_W-1:0] hdr_need;
  logic              hdr_no_room;
  logic              arg_no_room;
  logic              bstr_no_room;
  logic              has_room;
  logic              utf8_bad;
  logic [1:0]        cont_after;
  logic [3:0]        n_bytes;
  logic              close_str;

  // Argument size class; the argument is left-justified so that its
  // big-endian bytes always start at the top.
  always_comb begin
    priority if (argument < 64'd24) begin
      extra    = 4'd0;
      marker   = argument[4:0];
      arg_left = argument;
    end else if (argument < 64'h100) begin
      extra    = 4'd1;
      marker   = MARK_1;
      arg_left = {argument[7:0], 56'd0};
    end else if (argument < 64'h10000) begin
      extra    = 4'd2;
      marker   = MARK_2;
      arg_left = {argument[15:0], 48'd0};
    end else if (argument < 64'h1_0000_0000) begin
      extra    = 4'd4;
      marker   = MARK_4;
      arg_left = {argument[31:0], 32'd0};
    end else begin
      extra    = 4'd8;
      marker   = MARK_8;
      arg_left = argument;
    end
  end

  assign hdr_need     = NEED_W'(fill_level) + NEED_W'(extra) + NEED_W'(1);
  assign hdr_no_room  = hdr_need > CAP_NEED;
  assign arg_no_room  = hdr_need >= CAP_NEED;
  assign bstr_no_room = ({1'b0, argument} + 65'(hdr_need)) >= CAP_WIDE;
  assign has_room     = fill_level < CAP_FILL;

  // UTF-8 check of a text byte: continuation or lead byte.
  always_comb begin
    utf8_bad   = 1'b0;
    cont_after = continuation_pending;
    if (continuation_pending != 2'd0) begin
      cont_after = continuation_pending - 2'd1;
      utf8_bad   = data_byte[7:6] != 2'b10;
    end else if (data_byte[7]) begin
      priority if (data_byte[7:5] == 3'b110) begin
        cont_after = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        cont_after = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
        cont_after = 2'd3;
      end else begin
        utf8_bad = 1'b1;
      end
    end
  end

  always_comb begin
    fill_level_next           = fill_level;
    error_status_next         = error_status;
    string_kind_next          = string_kind;
    payload_remaining_next    = payload_remaining;
    continuation_pending_next = continuation_pending;
    text_overflowed_next      = text_overflowed;
    n_bytes                   = 4'd0;
    close_str                 = 1'b0;
    result.bytes              = '0;

    for (int k = 1; k < MAX_BEATS; k++) begin
      result.bytes[k] = arg_left[8*(MAX_BEATS-k)-1 -: 8];
    end

    unique case (action)
      ACT_CLEAR: begin
        fill_level_next   = '0;
        error_status_next = ST_OK;
        close_str         = 1'b1;
      end
      ACT_HEADER: begin
        if (error_status == ST_OK) begin
          priority if (string_kind != KIND_NONE) begin
            error_status_next = ST_MALFORMED;
          end else if (hdr_no_room) begin
            error_status_next = ST_ROOM;
          end else begin
            result.bytes[0] = {major_type, marker};
            n_bytes         = 4'd1;
            fill_level_next = fill_level + FILL_W'(1);
            if (arg_no_room) begin
              error_status_next = ST_ROOM;
            end else begin
              n_bytes         = 4'd1 + extra;
              fill_level_next = hdr_need[FILL_W-1:0];
              if (major_type == MT_BYTES) begin
                if (bstr_no_room) begin
                  error_status_next = ST_ROOM;
                end else if (argument != 64'd0) begin
                  string_kind_next       = KIND_BYTES;
                  payload_remaining_next = argument;
                end
              end else if (major_type == MT_TEXT && argument != 64'd0) begin
                string_kind_next       = KIND_TEXT;
                payload_remaining_next = argument;
              end
            end
          end
        end
      end
      ACT_PAYLOAD: begin
        result.bytes[0] = data_byte;
        if (error_status == ST_OK) begin
          if (string_kind == KIND_NONE) begin
            error_status_next = ST_MALFORMED;
          end else if (string_kind == KIND_BYTES) begin
            if (has_room) begin
              n_bytes         = 4'd1;
              fill_level_next = fill_level + FILL_W'(1);
            end else begin
              error_status_next = ST_ROOM;
            end
            payload_remaining_next = payload_remaining - 64'd1;
            close_str              = payload_remaining == 64'd1;
          end else if (utf8_bad) begin
            error_status_next = ST_UTF8;
            close_str         = 1'b1;
          end else begin
            continuation_pending_next = cont_after;
            if (has_room) begin
              n_bytes         = 4'd1;
              fill_level_next = fill_level + FILL_W'(1);
            end else begin
              text_overflowed_next = 1'b1;
            end
            payload_remaining_next = payload_remaining - 64'd1;
            if (payload_remaining == 64'd1) begin
              close_str = 1'b1;
              if (cont_after != 2'd0) begin
                error_status_next = ST_UTF8;
              end else if (text_overflowed || !has_room) begin
                error_status_next = ST_ROOM;
              end
            end
          end
        end
      end
      ACT_NONE: begin
      end
      default: begin
      end
    endcase

    if (close_str) begin
      string_kind_next          = KIND_NONE;
      payload_remaining_next    = '0;
      continuation_pending_next = '0;
      text_overflowed_next      = 1'b0;
    end

    // An item that appends nothing still yields one beat without a byte.
    result.has_byte = n_bytes != 4'd0;
    result.count    = result.has_byte ? BEAT_W'(n_bytes) : BEAT_W'(1);
    result.status   = error_status_next;
    if (!result.has_byte) begin
      result.bytes[0] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level           <= '0;
      error_status         <= ST_OK;
      string_kind          <= KIND_NONE;
      payload_remaining    <= '0;
      continuation_pending <= '0;
      text_overflowed      <= 1'b0;
    end else if (take) begin
      fill_level           <= fill_level_next;
      error_status         <= error_status_next;
      string_kind          <= string_kind_next;
      payload_remaining    <= payload_remaining_next;
      continuation_pending <= continuation_pending_next;
      text_overflowed      <= text_overflowed_next;
    end
  end

  `CBE_ASSERT_NOW(a_fill_in_range, clk, rst, 1'b1, fill_level <= CAP_FILL, "fill above capacity")
  `CBE_ASSERT_NOW(a_closed_is_clean, clk, rst, string_kind == KIND_NONE, payload_remaining == 64'd0 && continuation_pending == 2'd0 && !text_overflowed, "closed string left state behind")
  `CBE_ASSERT_NOW(a_open_has_length, clk, rst, string_kind != KIND_NONE, string_kind != 2'd1 && payload_remaining != 64'd0, "open string without payload")

endmodule

// ===== src/cbe_serializer.sv =====
// Output register that sends the beats of one encoded item one per cycle while m_axis_tready is high.
// Depends on cbe_pkg and the assertion macro header.
`include "cbor_header_and_string_encoder_macros.svh"

module cbe_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cbe_pkg::result_t result,
  output logic             can_load,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // out_byte [7:0], status [9:8], zeros [15:10]
  output logic [0:0]       m_axis_tuser,  // byte_valid [0]
  output logic             m_axis_tlast
);
  import cbe_pkg::*;

  logic                      valid;
  logic [BEAT_W-1:0]         beats;
  logic [MAX_BEATS-1:0][7:0] bytes;
  logic [1:0]                status;
  logic                      has_byte;
  logic                      last_beat;

  assign last_beat     = beats == BEAT_W'(1);
  assign can_load      = !valid || (m_axis_tready && last_beat);
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {6'd0, status, bytes[0]};
  assign m_axis_tuser  = has_byte;
  assign m_axis_tlast  = last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      beats <= '0;
    end else if (load) begin
      valid <= 1'b1;
      beats <= result.count;
    end else if (valid && m_axis_tready) begin
      valid <= !last_beat;
      beats <= beats - BEAT_W'(1);
    end
  end

  // Bytes move down one place per beat so that the next one sits at the port.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= result.bytes;
      status   <= result.status;
      has_byte <= result.has_byte;
    end else if (valid && m_axis_tready) begin
      bytes <= {8'd0, bytes[MAX_BEATS-1:1]};
    end
  end

  `CBE_ASSERT_NOW(a_empty_beat_alone, clk, rst, m_axis_tvalid && !m_axis_tuser[0], last_beat, "beat without byte is not the only one")
  `CBE_ASSERT_NOW(a_beats_in_range, clk, rst, m_axis_tvalid, beats != '0 && beats <= BEAT_W'(MAX_BEATS), "beat count out of range")
  `CBE_ASSERT_NEXT(a_beat_advance, clk, rst, m_axis_tvalid && m_axis_tready && !last_beat, m_axis_tvalid && beats == $past(beats) - BEAT_W'(1), "beat count did not step")

endmodule

// ===== src/cbor_header_and_string_encoder.sv =====
// Top level of the CBOR header and string encoder: input register,
// encoding core and output serializer. Depends on cbe_pkg and both submodules.
//
//   channel  direction  tdata fields (low bit first)                tuser       tlast
//   s_axis   in         major_type, argument, data_byte (80 bits)    action      -
//   m_axis   out        out_byte, status (16 bits)                  byte_valid  last
//
// A header item gives 1 to 9 output beats (initial byte plus 0, 1, 2, 4 or 8
// argument bytes); every other item gives exactly one beat.
// Items that give one beat stream at one per cycle while m_axis_tready is high;
// a header holds the output register until its last beat is taken.
// The input register takes a new item while the output register still holds
// beats, so a stalled m_axis side holds back at most one item.
// Reset is synchronous and clears the message, the error and any open string.
module cbor_header_and_string_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // major_type [2:0], argument [66:3], data_byte [74:67]
  input  logic [1:0]  s_axis_tuser,   // action [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte [7:0], status [9:8]
  output logic [0:0]  m_axis_tuser,   // byte_valid [0]
  output logic        m_axis_tlast
);
  import cbe_pkg::*;

  logic        in_valid;
  logic [1:0]  action;
  logic [2:0]  major_type;
  logic [63:0] argument;
  logic [7:0]  data_byte;
  logic        can_load;
  logic        load;
  result_t     result;

  assign load          = in_valid && can_load;
  assign s_axis_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      action     <= s_axis_tuser;
      major_type <= s_axis_tdata[2:0];
      argument   <= s_axis_tdata[66:3];
      data_byte  <= s_axis_tdata[74:67];
    end
  end

  cbe_encode_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (load),
    .action     (action),
    .major_type (major_type),
    .argument   (argument),
    .data_byte  (data_byte),
    .result     (result)
  );

  cbe_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .result        (result),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
